// File: sv/prefill_jitter_fifo_assert.svh
// Assertion macros for the jitter buffer. Every macro samples clk_i and is disabled in reset.
`ifndef PREFILL_JITTER_FIFO_ASSERT_SVH
`define PREFILL_JITTER_FIFO_ASSERT_SVH

`ifndef SYNTH

`define PJF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("jitter buffer assertion failed");

`define PJF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jitter buffer assertion failed");

`define PJF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jitter buffer assertion failed");

`else

`define PJF_ASSERT(lbl, prop)
`define PJF_ASSERT_IMPL(lbl, ante, cons)
`define PJF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: sv/pjf_pkg.sv
package pjf_pkg;

  localparam int unsigned DEPTH = 16384;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned THR_W = 15;
  localparam int unsigned CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int unsigned SMP_W = 16;
  localparam logic [THR_W-1:0] THR_RESET = 15'd12288;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [SMP_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    write_dropped;
    logic                    read_valid;
    logic                    playing;
  } out_t;

  typedef struct packed {
    logic pend;
    logic dropped;
    logic valid;
    logic playing;
  } stat_t;

endpackage

// File: sv/pjf_ram.sv
module pjf_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pjf_ctrl.sv
`include "prefill_jitter_fifo_assert.svh"

module pjf_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  pjf_pkg::in_t                  item_i,
  input  logic [pjf_pkg::THR_W-1:0]     thr_i,
  output logic                          ram_we_o,
  output logic [pjf_pkg::PTR_W-1:0]     ram_waddr_o,
  output logic [pjf_pkg::SMP_W-1:0]     ram_wdata_o,
  output logic [pjf_pkg::PTR_W-1:0]     ram_raddr_o,
  output pjf_pkg::stat_t                stat_o
);

  localparam logic [pjf_pkg::PTR_W-1:0] PTR_LAST = pjf_pkg::PTR_W'(pjf_pkg::DEPTH - 1);
  localparam logic [pjf_pkg::CNT_W-1:0] CNT_FULL = pjf_pkg::CNT_W'(pjf_pkg::DEPTH);

  logic [pjf_pkg::PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [pjf_pkg::PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [pjf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      play_q, play_d;
  pjf_pkg::stat_t            stat_q, stat_d;
  logic [pjf_pkg::THR_W-1:0] thr_eff;
  logic                      full, empty, reached, do_write, do_pop;

  assign thr_eff = (thr_i == '0) ? pjf_pkg::THR_W'(1) : thr_i;
  assign full    = (cnt_q == CNT_FULL);
  assign empty   = (cnt_q == '0);
  assign reached = pjf_pkg::CMP_W'(cnt_q) >= pjf_pkg::CMP_W'(thr_eff);

  always_comb begin
    do_write = 1'b0;
    do_pop   = 1'b0;
    play_d   = play_q;
    stat_d   = '0;
    if (accept_i) begin
      stat_d.pend = 1'b1;
      case (item_i.cmd)
        pjf_pkg::CMD_WRITE: begin
          if (full) begin
            stat_d.dropped = 1'b1;
          end else begin
            do_write = 1'b1;
          end
        end
        pjf_pkg::CMD_READ: begin
          if (play_q) begin
            if (empty) begin
              play_d = 1'b0;
            end else begin
              do_pop = 1'b1;
            end
          end else if (reached) begin
            play_d = 1'b1;
            do_pop = 1'b1;
          end
        end
        default: begin
          stat_d.pend = 1'b1;
        end
      endcase
      stat_d.valid   = do_pop;
      stat_d.playing = play_d;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_write) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      cnt_d    = cnt_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      cnt_d    = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      play_q   <= 1'b0;
      stat_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      play_q   <= play_d;
      stat_q   <= stat_d;
    end
  end

  // The read address is always the oldest entry; the read data lands together with stat_q.
  assign ram_we_o    = do_write;
  assign ram_waddr_o = wr_ptr_q;
  assign ram_wdata_o = item_i.sample_in;
  assign ram_raddr_o = rd_ptr_q;
  assign stat_o      = stat_q;

  `PJF_ASSERT(a_cnt_bound, cnt_q <= CNT_FULL)
  `PJF_ASSERT_IMPL(a_empty_ptrs, cnt_q == '0, wr_ptr_q == rd_ptr_q)
  `PJF_ASSERT_NEXT(a_accept_pend, accept_i, stat_q.pend && (stat_q.playing == play_q))
  `PJF_ASSERT_IMPL(a_pop_plays, stat_q.valid, stat_q.playing && !stat_q.dropped)

endmodule

// File: sv/prefill_jitter_fifo.sv
// At an item's acceptance edge the controller registers its status and the memory reads the
// oldest sample; the output register then captures both and offers the result.
// The input is held off while that status is pending, in the cycle in which the memory
// read of the oldest sample completes, and while a finished result is not taken.
// Reset clears pointers, fill count and play state and sets the threshold to 12288.
// The memory is not cleared. Configuration writes are taken in any cycle.
`include "prefill_jitter_fifo_assert.svh"

module prefill_jitter_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pjf_pkg::THR_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pjf_pkg::in_t                  in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pjf_pkg::out_t                 out_item_o
);

  logic [pjf_pkg::THR_W-1:0] thr_q;
  logic                      accept;
  logic                      ram_we;
  logic [pjf_pkg::PTR_W-1:0] ram_waddr, ram_raddr;
  logic [pjf_pkg::SMP_W-1:0] ram_wdata, ram_rdata;
  pjf_pkg::stat_t            stat;
  logic                      out_valid_q;
  pjf_pkg::out_t             out_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !stat.pend && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= pjf_pkg::THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  pjf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .thr_i       (thr_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .stat_o      (stat)
  );

  pjf_ram #(
    .DEPTH (pjf_pkg::DEPTH),
    .WIDTH (pjf_pkg::SMP_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.pend) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.pend) begin
      out_q.sample_out    <= stat.valid ? ram_rdata : '0;
      out_q.write_dropped <= stat.dropped;
      out_q.read_valid    <= stat.valid;
      out_q.playing       <= stat.playing;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PJF_ASSERT_NEXT(a_pend_out, stat.pend, out_valid_q)
  `PJF_ASSERT_IMPL(a_pend_blocks, stat.pend, !in_ready_o)
  `PJF_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i, out_valid_q)

endmodule
